FILE: rtl/core/command_byte_decoder_unit_defines.svh
// Assertion macros for the command byte decoder response register.
`ifndef COMMAND_BYTE_DECODER_UNIT_DEFINES_SVH
`define COMMAND_BYTE_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Checked outside reset.
`define CBD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("command byte decoder assertion failed");
// Checked at every edge, reset included.
`define CBD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("command byte decoder assertion failed");
`else
`define CBD_ASSERT(lbl, prop)
`define CBD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/core/cbd_pkg.sv
// Types and codes shared by the command byte decoder modules.
package cbd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] bytes_waiting;
  } cbd_in_t;

  typedef struct packed {
    logic [7:0] resp_byte;
    logic       resp_last;
  } cbd_out_t;

  // Response descriptor handed from the decoder to the response stage.
  typedef struct packed {
    logic        valid;
    logic        burst;
    logic [7:0]  code;
    logic [2:0]  mode;
    logic [15:0] wing;
  } cbd_resp_t;

  localparam logic [7:0] RESP_OK   = 8'h00;
  localparam logic [7:0] ERR_TYPE  = 8'hE0;
  localparam logic [7:0] ERR_MODE  = 8'hE1;
  localparam logic [7:0] ERR_RANGE = 8'hE2;
  localparam logic [7:0] ERR_SHORT = 8'hE3;

  localparam logic [3:0] CMD_MODE   = 4'h1;
  localparam logic [3:0] CMD_MOTION = 4'h2;
  localparam logic [3:0] CMD_WING   = 4'h3;
  localparam logic [3:0] CMD_MOUTH  = 4'h4;
  localparam logic [3:0] CMD_STATUS = 4'hF;

  localparam logic [3:0] MOTION_LEN = 4'd9;
  localparam logic [3:0] WING_LEN   = 4'd2;
  localparam logic [3:0] MODE_MAX   = 4'd5;

  localparam logic signed [15:0] ANGLE_LIMIT = 16'sd450;
  localparam logic signed [7:0]  RATE_LIMIT  = 8'sd100;

  localparam logic [2:0] STATUS_LAST = 3'd7;

  function automatic logic angle_ok(input logic [15:0] a);
    return ($signed(a) >= -ANGLE_LIMIT) && ($signed(a) <= ANGLE_LIMIT);
  endfunction

  // Sign clear, not zero, not a NaN.
  function automatic logic period_positive(input logic [31:0] b);
    return !b[31] && (b != 32'd0) && !((&b[30:23]) && (|b[22:0]));
  endfunction

endpackage

FILE: rtl/core/cbd_decode.sv
// Command decoder: phase, payload collection, settings registers.
module cbd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  cbd_pkg::cbd_in_t  item,
  output cbd_pkg::cbd_resp_t rsp
);
  import cbd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MOTION,
    PH_WING,
    PH_SPARE
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  payload_count, payload_count_next;
  logic [7:0]  payload_store [MOTION_LEN];
  logic [3:0]  pending_sub, pending_sub_next;
  logic [2:0]  motion_mode, motion_mode_next;
  logic [1:0]  wing_select, wing_select_next;
  logic        mouth_open, mouth_open_next;
  logic [15:0] wing_tenths, wing_tenths_next;
  logic [15:0] max_angle_tenths, max_angle_tenths_next;
  logic [7:0]  rate_hundredths, rate_hundredths_next;
  logic [31:0] period_bits, period_bits_next;

  logic [3:0]  cmd_type, cmd_sub;
  logic [31:0] per;
  logic [15:0] w_ang, m_ang, a_ang;
  logic [7:0]  rate;

  assign cmd_type = item.data_byte[7:4];
  assign cmd_sub  = item.data_byte[3:0];
  // The final payload byte is taken straight from the input.
  assign per   = {payload_store[3], payload_store[2], payload_store[1], payload_store[0]};
  assign w_ang = {payload_store[5], payload_store[4]};
  assign m_ang = {payload_store[7], payload_store[6]};
  assign rate  = item.data_byte;
  assign a_ang = {item.data_byte, payload_store[0]};

  always_comb begin
    phase_next            = phase;
    payload_count_next    = payload_count;
    pending_sub_next      = pending_sub;
    motion_mode_next      = motion_mode;
    wing_select_next      = wing_select;
    mouth_open_next       = mouth_open;
    wing_tenths_next      = wing_tenths;
    max_angle_tenths_next = max_angle_tenths;
    rate_hundredths_next  = rate_hundredths;
    period_bits_next      = period_bits;
    rsp       = '0;
    rsp.mode  = motion_mode;
    rsp.wing  = wing_tenths;
    if (accept) begin
      case (phase)
        PH_MOTION: begin
          payload_count_next = payload_count + 4'd1;
          if (payload_count == MOTION_LEN - 4'd1) begin
            payload_count_next = '0;
            phase_next         = PH_IDLE;
            rsp.valid          = 1'b1;
            if (angle_ok(w_ang) && angle_ok(m_ang) && period_positive(per) &&
                ($signed(rate) >= -RATE_LIMIT) && ($signed(rate) <= RATE_LIMIT)) begin
              period_bits_next      = per;
              wing_tenths_next      = w_ang;
              max_angle_tenths_next = m_ang;
              rate_hundredths_next  = rate;
              rsp.code              = RESP_OK;
            end else begin
              rsp.code = ERR_RANGE;
            end
          end
        end
        PH_WING: begin
          payload_count_next = payload_count + 4'd1;
          if (payload_count == WING_LEN - 4'd1) begin
            payload_count_next = '0;
            phase_next         = PH_IDLE;
            rsp.valid          = 1'b1;
            if (angle_ok(a_ang) && (pending_sub inside {[4'd1:4'd3]})) begin
              wing_select_next = pending_sub[1:0];
              wing_tenths_next = a_ang;
              rsp.code         = RESP_OK;
            end else begin
              rsp.code = ERR_RANGE;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
          rsp.valid  = 1'b1;
          case (cmd_type)
            CMD_MODE: begin
              if (cmd_sub <= MODE_MAX) begin
                motion_mode_next = cmd_sub[2:0];
                rsp.code         = RESP_OK;
              end else begin
                rsp.code = ERR_MODE;
              end
            end
            CMD_MOTION, CMD_WING: begin
              if (item.bytes_waiting >=
                  {4'd0, (cmd_type == CMD_MOTION) ? MOTION_LEN : WING_LEN}) begin
                phase_next         = (cmd_type == CMD_MOTION) ? PH_MOTION : PH_WING;
                payload_count_next = '0;
                pending_sub_next   = cmd_sub;
                rsp.valid          = 1'b0;
              end else begin
                rsp.code = ERR_SHORT;
              end
            end
            CMD_MOUTH: begin
              mouth_open_next = cmd_sub[0];
              rsp.code        = RESP_OK;
            end
            CMD_STATUS: rsp.burst = 1'b1;
            default:    rsp.code  = ERR_TYPE;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      payload_count    <= '0;
      pending_sub      <= '0;
      motion_mode      <= '0;
      wing_select      <= 2'd3;
      mouth_open       <= 1'b0;
      wing_tenths      <= '0;
      max_angle_tenths <= '0;
      rate_hundredths  <= '0;
      period_bits      <= '0;
    end else begin
      phase            <= phase_next;
      payload_count    <= payload_count_next;
      pending_sub      <= pending_sub_next;
      motion_mode      <= motion_mode_next;
      wing_select      <= wing_select_next;
      mouth_open       <= mouth_open_next;
      wing_tenths      <= wing_tenths_next;
      max_angle_tenths <= max_angle_tenths_next;
      rate_hundredths  <= rate_hundredths_next;
      period_bits      <= period_bits_next;
    end
  end

  // Payload bytes land at the running count.
  always_ff @(posedge clk) begin
    if (accept && (phase == PH_MOTION || phase == PH_WING) &&
        (payload_count < MOTION_LEN)) begin
      payload_store[payload_count] <= item.data_byte;
    end
  end

endmodule

FILE: rtl/core/cbd_resp.sv
// Response register: holds one response and steps through a status burst.
module cbd_resp (
  input  logic                clk,
  input  logic                rst,
  input  cbd_pkg::cbd_resp_t  load,
  output logic                can_load,
  output logic                valid,
  input  logic                stall,
  output cbd_pkg::cbd_out_t   data
);
  import cbd_pkg::*;
  `include "command_byte_decoder_unit_defines.svh"

  logic        busy;
  logic        burst;
  logic [2:0]  beat;
  logic [7:0]  code;
  logic [2:0]  mode;
  logic [15:0] wing;
  logic        last;
  logic        finish;

  assign last     = !burst || (beat == STATUS_LAST);
  assign finish   = busy && !stall && last;
  assign can_load = !busy || finish;
  assign valid    = busy;

  always_comb begin
    data.resp_last = last;
    if (burst) begin
      case (beat)
        3'd0:    data.resp_byte = {5'd0, mode};
        3'd1:    data.resp_byte = wing[7:0];
        3'd2:    data.resp_byte = wing[15:8];
        default: data.resp_byte = 8'd0;
      endcase
    end else begin
      data.resp_byte = code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      burst <= 1'b0;
      beat  <= '0;
    end else if (load.valid) begin
      busy  <= 1'b1;
      burst <= load.burst;
      beat  <= '0;
    end else if (busy && !stall) begin
      // Drop the transaction on its last byte, else advance the beat.
      if (last) begin
        busy <= 1'b0;
      end else begin
        beat <= beat + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      code <= load.code;
      mode <= load.mode;
      wing <= load.wing;
    end
  end

  `CBD_ASSERT(a_load_only_when_free, load.valid |-> can_load)
  `CBD_ASSERT(a_beat_advances, busy && burst && !stall && !last |=> busy && (beat == $past(beat) + 3'd1))
  `CBD_ASSERT(a_stall_holds, busy && stall && !load.valid |=> busy && $stable(beat))
  `CBD_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !busy)

endmodule

FILE: rtl/core/command_byte_decoder_unit.sv
// Top level of the command byte decoder.
//
//  channel | direction | payload   | handshake
//  req     | in        | cbd_in_t  | req_valid, req_stall
//  rsp     | out       | cbd_out_t | rsp_valid, rsp_stall
//
// One byte is taken per cycle while req_stall is low; its response is registered and
// shows in the next cycle. A status command gives a burst of eight bytes; a new byte is
// taken only as the last of them drains. Every other response is a single byte.
// A byte is taken whenever the response register is empty or drains in that cycle.
// Synchronous reset returns to the command phase with default settings.
// A stalled response holds, and the request side stalls behind it.
module command_byte_decoder_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  cbd_pkg::cbd_in_t  req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output cbd_pkg::cbd_out_t rsp
);
  import cbd_pkg::*;

  logic      accept;
  logic      can_load;
  cbd_resp_t desc;

  assign req_stall = !can_load;
  assign accept    = req_valid && can_load;

  cbd_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (req),
    .rsp    (desc)
  );

  cbd_resp u_resp (
    .clk      (clk),
    .rst      (rst),
    .load     (desc),
    .can_load (can_load),
    .valid    (rsp_valid),
    .stall    (rsp_stall),
    .data     (rsp)
  );

endmodule

FILE: sim/command_byte_decoder_unit_checker.sv
// Checker for the command byte decoder: predicts responses from accepted bytes and compares.
module command_byte_decoder_unit_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  cbd_pkg::cbd_in_t  req,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  cbd_pkg::cbd_out_t rsp,
  output int                fail_count,
  output int                pending,
  output int                responses_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import cbd_pkg::*;

  typedef enum logic [1:0] {AWAIT_CMD, TAKE_MOTION, TAKE_WING} collect_e;

  collect_e   collect_q;
  logic [3:0] taken_q;
  logic [7:0] payload_q [0:8];
  logic [3:0] held_sub_q;
  logic [2:0] mode_q;
  logic [15:0] wing_q;

  cbd_out_t awaited_responses [$];
  cbd_out_t oldest;
  int       mismatches;
  int       seen;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("ERROR at %0t ns: %s: got %02h, want %02h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic await_response(input logic [7:0] code, input logic last);
    cbd_out_t r;
    r.resp_byte = code;
    r.resp_last = last;
    awaited_responses.push_back(r);
  endtask

  function automatic logic in_tenths(input logic signed [15:0] a);
    return a >= -ANGLE_LIMIT && a <= ANGLE_LIMIT;
  endfunction

  // Positive means sign clear, non-zero and not a NaN; denormals and +inf pass.
  function automatic logic positive_float(input logic [31:0] b);
    return !b[31] && b != 32'd0 && !(b[30:23] == 8'hFF && b[22:0] != 23'd0);
  endfunction

  // Advance the decoder state by one byte and queue whatever it answers.
  task automatic decode_byte(input cbd_in_t item);
    logic [3:0]         kind;
    logic [3:0]         sub;
    logic [31:0]        per;
    logic signed [15:0] wing;
    logic signed [15:0] max_angle;
    logic signed [7:0]  rate;
    kind = item.data_byte[7:4];
    sub  = item.data_byte[3:0];
    if (collect_q == TAKE_MOTION || collect_q == TAKE_WING) begin
      payload_q[taken_q] = item.data_byte;
      taken_q = taken_q + 4'd1;
      if (collect_q == TAKE_MOTION && taken_q == MOTION_LEN) begin
        collect_q = AWAIT_CMD;
        taken_q   = 4'd0;
        per       = {payload_q[3], payload_q[2], payload_q[1], payload_q[0]};
        wing      = {payload_q[5], payload_q[4]};
        max_angle = {payload_q[7], payload_q[6]};
        rate      = payload_q[8];
        // Period, max angle and rate are not visible in any response; drop them.
        if (in_tenths(wing) && in_tenths(max_angle) && rate >= -RATE_LIMIT &&
            rate <= RATE_LIMIT && positive_float(per)) begin
          wing_q = wing;
          await_response(RESP_OK, 1'b1);
        end else begin
          await_response(ERR_RANGE, 1'b1);
        end
      end else if (collect_q == TAKE_WING && taken_q == WING_LEN) begin
        collect_q = AWAIT_CMD;
        taken_q   = 4'd0;
        wing      = {payload_q[1], payload_q[0]};
        if (in_tenths(wing) && held_sub_q >= 4'd1 && held_sub_q <= 4'd3) begin
          wing_q = wing;
          await_response(RESP_OK, 1'b1);
        end else begin
          await_response(ERR_RANGE, 1'b1);
        end
      end
      return;
    end
    collect_q = AWAIT_CMD;
    case (kind)
      CMD_MODE: begin
        if (sub <= MODE_MAX) begin
          mode_q = sub[2:0];
          await_response(RESP_OK, 1'b1);
        end else begin
          await_response(ERR_MODE, 1'b1);
        end
      end
      CMD_MOTION: begin
        if (item.bytes_waiting >= MOTION_LEN) begin
          collect_q  = TAKE_MOTION;
          taken_q    = 4'd0;
          held_sub_q = sub;
        end else begin
          await_response(ERR_SHORT, 1'b1);
        end
      end
      CMD_WING: begin
        if (item.bytes_waiting >= WING_LEN) begin
          collect_q  = TAKE_WING;
          taken_q    = 4'd0;
          held_sub_q = sub;
        end else begin
          await_response(ERR_SHORT, 1'b1);
        end
      end
      CMD_MOUTH: await_response(RESP_OK, 1'b1);
      CMD_STATUS: begin
        await_response({5'd0, mode_q}, 1'b0);
        await_response(wing_q[7:0], 1'b0);
        await_response(wing_q[15:8], 1'b0);
        for (int k = 3; k <= 7; k++) await_response(8'h00, k == STATUS_LAST);
      end
      default: await_response(ERR_TYPE, 1'b1);
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      collect_q  = AWAIT_CMD;
      taken_q    = 4'd0;
      held_sub_q = 4'd0;
      mode_q     = 3'd0;
      wing_q     = 16'd0;
      awaited_responses.delete();
    end else begin
      // The response register is filled in the cycle after its byte, so check first.
      if (rsp_valid && !rsp_stall) begin
        seen++;
        if (awaited_responses.size() == 0) begin
          report_mismatch("response with none awaited", rsp.resp_byte, 8'h00);
        end else begin
          oldest = awaited_responses.pop_front();
          if (rsp.resp_byte !== oldest.resp_byte)
            report_mismatch("resp_byte", rsp.resp_byte, oldest.resp_byte);
          if (rsp.resp_last !== oldest.resp_last)
            report_mismatch("resp_last", {7'd0, rsp.resp_last}, {7'd0, oldest.resp_last});
        end
      end
      if (req_valid && !req_stall) decode_byte(req);
    end
    fail_count     <= mismatches;
    pending        <= awaited_responses.size();
    responses_seen <= seen;
  end

endmodule

FILE: sim/command_byte_decoder_unit_test.sv
// Testbench top for the command byte decoder: stimulus, flow control and verdict.
module command_byte_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cbd_pkg::*;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  cbd_in_t  req;
  logic     rsp_valid;
  logic     rsp_stall;
  cbd_out_t rsp;

  int fail_count;
  int pending;
  int responses_seen;
  int bytes_sent;
  int phase_bytes;
  int send_idle_pct;
  int recv_stall_pct;
  int waited;

  command_byte_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  command_byte_decoder_unit_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp            (rsp),
    .fail_count     (fail_count),
    .pending        (pending),
    .responses_seen (responses_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d responses outstanding", pending);
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: stall at random at the rate set for the current phase.
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      rsp_stall <= !rst && ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] data, input logic [7:0] waiting);
    cbd_in_t item;
    item.data_byte     = data;
    item.bytes_waiting = waiting;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
    bytes_sent++;
    phase_bytes++;
  endtask

  function automatic logic [15:0] pick_tenths();
    int v;
    case ($urandom_range(0, 7))
      0: v = 450;
      1: v = -450;
      2: v = 451;
      3: v = -451;
      4: v = $urandom;
      default: v = int'($urandom_range(0, 900)) - 450;
    endcase
    return v[15:0];
  endfunction

  function automatic logic [7:0] pick_rate();
    int v;
    case ($urandom_range(0, 7))
      0: v = 100;
      1: v = -100;
      2: v = 101;
      3: v = -101;
      4: v = $urandom;
      default: v = int'($urandom_range(0, 200)) - 100;
    endcase
    return v[7:0];
  endfunction

  function automatic logic [31:0] pick_period();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return {1'b1, 31'($urandom)};
      2: return {1'b0, 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
      3: return 32'h7F80_0000;
      4: return {9'd0, 23'($urandom_range(1, 23'h7F_FFFF))};
      default: return {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
    endcase
  endfunction

  // One command with random content; payload transactions are mostly well-formed.
  task automatic send_random_command();
    int          sel;
    logic [31:0] per;
    logic [15:0] wing;
    logic [15:0] max_angle;
    logic [7:0]  rate;
    logic [3:0]  sub;
    logic [3:0]  kind;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      per       = pick_period();
      wing      = pick_tenths();
      max_angle = pick_tenths();
      rate      = pick_rate();
      if ($urandom_range(0, 9) == 0) begin
        send_byte({CMD_MOTION, 4'($urandom)}, 8'($urandom_range(0, 8)));
      end else begin
        send_byte({CMD_MOTION, 4'($urandom)}, 8'($urandom_range(9, 255)));
        send_byte(per[7:0], 8'($urandom));
        send_byte(per[15:8], 8'($urandom));
        send_byte(per[23:16], 8'($urandom));
        send_byte(per[31:24], 8'($urandom));
        send_byte(wing[7:0], 8'($urandom));
        send_byte(wing[15:8], 8'($urandom));
        send_byte(max_angle[7:0], 8'($urandom));
        send_byte(max_angle[15:8], 8'($urandom));
        send_byte(rate, 8'($urandom));
      end
    end else if (sel < 50) begin
      wing = pick_tenths();
      sub  = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(1, 3)) : 4'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        send_byte({CMD_WING, sub}, 8'($urandom_range(0, 1)));
      end else begin
        send_byte({CMD_WING, sub}, 8'($urandom_range(2, 255)));
        send_byte(wing[7:0], 8'($urandom));
        send_byte(wing[15:8], 8'($urandom));
      end
    end else if (sel < 62) begin
      send_byte({CMD_MODE, 4'($urandom)}, 8'($urandom));
    end else if (sel < 72) begin
      send_byte({CMD_MOUTH, 4'($urandom)}, 8'($urandom));
    end else if (sel < 82) begin
      send_byte({CMD_STATUS, 4'($urandom)}, 8'($urandom));
    end else if (sel < 92) begin
      kind = ($urandom_range(0, 4) == 0) ? 4'h0 : 4'($urandom_range(5, 14));
      send_byte({kind, 4'($urandom)}, 8'($urandom));
    end else begin
      send_byte(8'($urandom), 8'($urandom));
    end
  endtask

  task automatic run_mix(input int idle_pct, input int stall_pct, input int n_bytes);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    phase_bytes    = 0;
    while (phase_bytes < n_bytes) send_random_command();
  endtask

  initial begin
    rst            = 1'b1;
    req_valid      = 1'b0;
    req            = '0;
    bytes_sent     = 0;
    phase_bytes    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: status at reset, mode bounds, mouth, unknown types, short payloads.
    send_byte({CMD_STATUS, 4'h0}, 8'd0);
    send_byte({CMD_MODE, 4'h0}, 8'd255);
    send_byte({CMD_MODE, 4'h5}, 8'd0);
    send_byte({CMD_MODE, 4'h6}, 8'd0);
    send_byte({CMD_MOUTH, 4'h1}, 8'd0);
    send_byte({CMD_MOUTH, 4'hE}, 8'd0);
    send_byte(8'h00, 8'd0);
    send_byte(8'hA5, 8'd3);
    send_byte({CMD_MOTION, 4'h0}, 8'd8);
    send_byte({CMD_WING, 4'h0}, 8'd1);
    send_byte({CMD_WING, 4'h1}, 8'd0);
    // Full motion payload: period 1.0, wing -45.0, max +45.0, rate -1.00.
    send_byte({CMD_MOTION, 4'hF}, 8'd9);
    send_byte(8'h00, 8'd8);
    send_byte(8'h00, 8'd7);
    send_byte(8'h80, 8'd6);
    send_byte(8'h3F, 8'd5);
    send_byte(8'h3E, 8'd4);
    send_byte(8'hFE, 8'd3);
    send_byte(8'hC2, 8'd2);
    send_byte(8'h01, 8'd1);
    send_byte(8'h9C, 8'd0);
    // Wing command at the upper angle bound, then read it back.
    send_byte({CMD_WING, 4'h3}, 8'd255);
    send_byte(8'hC2, 8'd1);
    send_byte(8'h01, 8'd0);
    send_byte({CMD_STATUS, 4'hF}, 8'd0);

    run_mix(0, 0, 100);
    run_mix(65, 0, 100);
    run_mix(0, 65, 100);
    run_mix(35, 35, 100);
    req_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (pending != 0) $display("ERROR: %0d responses never arrived", pending);

    $display("Sent %0d request bytes and checked %0d response bytes", bytes_sent,
             responses_seen);
    $display("over directed commands and four mixes of sender gaps and receiver stalls");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
